[hdl/rgb_led_fade_blink_sequencer_core_macros.svh]
// Assertion macros shared by the RGB LED sequencer RTL.
`ifndef RGB_LED_FADE_BLINK_SEQUENCER_CORE_MACROS_SVH
`define RGB_LED_FADE_BLINK_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checks a condition at every rising clock edge outside reset.
`define RGBFB_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define RGBFB_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RGBFB_ASSERT(name, cond, msg)
`define RGBFB_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[hdl/rgbfb_pkg.sv]
// Types, codes and constants shared by the RGB LED sequencer RTL.
package rgbfb_pkg;

    localparam int LEVEL_W = 7;
    localparam int PHASE_W = 5;
    localparam int TICK_W  = 12;
    localparam int DUTY_W  = 16;
    localparam int PROD_W  = DUTY_W + LEVEL_W;

    localparam logic [2:0] PAT_OFF     = 3'd0;
    localparam logic [2:0] PAT_WAKE    = 3'd1;
    localparam logic [2:0] PAT_SUCCESS = 3'd2;
    localparam logic [2:0] PAT_MULTI   = 3'd3;
    localparam logic [2:0] PAT_FAIL    = 3'd4;
    localparam logic [2:0] PAT_COMM    = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [2:0] CFG_DUTY_FULL_SCALE  = 3'd0;
    localparam logic [2:0] CFG_RISE_STEP_TICKS  = 3'd1;
    localparam logic [2:0] CFG_FALL_STEP_TICKS  = 3'd2;
    localparam logic [2:0] CFG_HOLD_TICKS       = 3'd3;
    localparam logic [2:0] CFG_SLOW_BLINK_TICKS = 3'd4;
    localparam logic [2:0] CFG_FAST_BLINK_TICKS = 3'd5;
    localparam logic [2:0] CFG_BLINK_TOGGLES    = 3'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
    localparam logic [LEVEL_W-1:0] FADE_TOP   = 7'd99;
    localparam logic [TICK_W-1:0]  TICK_MAX   = 12'd4095;

    localparam logic [DUTY_W-1:0] RST_DUTY_FULL_SCALE  = 16'd1000;
    localparam logic [TICK_W-1:0] RST_RISE_STEP_TICKS  = 12'd12;
    localparam logic [TICK_W-1:0] RST_FALL_STEP_TICKS  = 12'd8;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS       = 12'd1000;
    localparam logic [TICK_W-1:0] RST_SLOW_BLINK_TICKS = 12'd300;
    localparam logic [TICK_W-1:0] RST_FAST_BLINK_TICKS = 12'd100;
    localparam logic [PHASE_W-1:0] RST_BLINK_TOGGLES   = 5'd20;

    // ceil(2^30 / 100); exact floor division by 100 for every product below 2^23.
    localparam logic [23:0] DIV100_RECIP = 24'd10737419;

    typedef struct packed {
        logic       action;
        logic [2:0] pattern;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [DUTY_W-1:0]  red_compare;
        logic [DUTY_W-1:0]  green_compare;
        logic [DUTY_W-1:0]  blue_compare;
        logic [2:0]         current_pattern;
        logic               sleep_allowed;
    } result_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_full_scale;
        logic [TICK_W-1:0]  rise_step_ticks;
        logic [TICK_W-1:0]  fall_step_ticks;
        logic [TICK_W-1:0]  hold_ticks;
        logic [TICK_W-1:0]  slow_blink_ticks;
        logic [TICK_W-1:0]  fast_blink_ticks;
        logic [PHASE_W-1:0] blink_toggles;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               armed;
        logic [TICK_W-1:0]  ticks;
    } chan_t;

    typedef struct packed {
        logic [2:0]      pattern;
        chan_t [2:0]     chan;
        logic            stop_permitted;
        logic            blink_multi;
        logic            blink_comm;
    } seq_state_t;

    function automatic logic [DUTY_W-1:0] div100(input logic [PROD_W-1:0] p);
        logic [46:0] prod;
        prod = 47'(p) * 47'(DIV100_RECIP);
        return prod[45:30];
    endfunction

endpackage

[hdl/rgbfb_step.sv]
// Next-state logic of the sequencer for one tick or start command.
module rgbfb_step (
    input  rgbfb_pkg::seq_state_t cur,
    input  rgbfb_pkg::item_t      cmd,
    input  rgbfb_pkg::cfg_t       cfg,
    output rgbfb_pkg::seq_state_t nxt
);

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_UP,
        MODE_HOLD,
        MODE_DOWN,
        MODE_BLINK
    } mode_t;

    localparam logic [rgbfb_pkg::PHASE_W-1:0] PHASE_RISE = 5'd0;
    localparam logic [rgbfb_pkg::PHASE_W-1:0] PHASE_HOLD = 5'd1;
    localparam logic [rgbfb_pkg::PHASE_W-1:0] PHASE_FALL = 5'd2;

    always_comb
    begin
        logic [1:0]                       ch;
        mode_t                            mode;
        rgbfb_pkg::chan_t                 c;
        rgbfb_pkg::chan_t                 c_n;
        logic [rgbfb_pkg::TICK_W-1:0]     interval;
        logic                             expired;
        logic                             end_pat;
        logic                             flip;
        logic                             blink_bit;

        nxt = cur;

        case (cur.pattern)
            rgbfb_pkg::PAT_SUCCESS: ch = rgbfb_pkg::CH_GREEN;
            rgbfb_pkg::PAT_FAIL:    ch = rgbfb_pkg::CH_RED;
            rgbfb_pkg::PAT_COMM:    ch = rgbfb_pkg::CH_RED;
            default:                ch = rgbfb_pkg::CH_BLUE;
        endcase
        c = cur.chan[ch];

        case (cur.pattern)
            rgbfb_pkg::PAT_WAKE:
            begin
                if (c.phase == PHASE_RISE)
                    mode = MODE_UP;
                else if (c.phase == PHASE_HOLD)
                    mode = MODE_HOLD;
                else
                    mode = MODE_DOWN;
            end
            rgbfb_pkg::PAT_SUCCESS, rgbfb_pkg::PAT_FAIL:
                mode = (c.phase == PHASE_RISE) ? MODE_UP : MODE_DOWN;
            rgbfb_pkg::PAT_MULTI, rgbfb_pkg::PAT_COMM:
                mode = MODE_BLINK;
            default:
                mode = MODE_NONE;
        endcase

        blink_bit = (cur.pattern == rgbfb_pkg::PAT_MULTI) ? cur.blink_multi : cur.blink_comm;

        case (mode)
            MODE_DOWN:  interval = cfg.fall_step_ticks;
            MODE_HOLD:  interval = cfg.hold_ticks;
            MODE_BLINK: interval = (cur.pattern == rgbfb_pkg::PAT_MULTI) ?
                                   cfg.slow_blink_ticks : cfg.fast_blink_ticks;
            default:    interval = cfg.rise_step_ticks;
        endcase

        // An idle timer spends this tick arming itself.
        c_n = c;
        c_n.armed = 1'b1;
        if (!c.armed)
        begin
            c_n.ticks = '0;
            expired = 1'b0;
        end
        else
        begin
            c_n.ticks = (c.ticks == rgbfb_pkg::TICK_MAX) ? c.ticks : c.ticks + 12'd1;
            expired = (c_n.ticks >= interval);
        end

        end_pat = 1'b0;
        flip = 1'b0;
        case (mode)
            MODE_UP:
            begin
                if (expired)
                begin
                    c_n.armed = 1'b0;
                    if (c.level < rgbfb_pkg::LEVEL_FULL)
                        c_n.level = c.level + 7'd1;
                end
                if (c_n.level >= rgbfb_pkg::FADE_TOP)
                begin
                    c_n.phase = c.phase + 5'd1;
                    c_n.armed = 1'b0;
                end
            end
            MODE_HOLD:
            begin
                if (expired)
                begin
                    c_n.armed = 1'b0;
                    c_n.phase = PHASE_FALL;
                end
            end
            MODE_DOWN:
            begin
                if (expired)
                begin
                    c_n.armed = 1'b0;
                    if (c.level != '0)
                        c_n.level = c.level - 7'd1;
                end
                end_pat = (c_n.level == '0);
            end
            MODE_BLINK:
            begin
                if (c.phase >= cfg.blink_toggles)
                    end_pat = 1'b1;
                else if (expired)
                begin
                    c_n.ticks = '0;
                    c_n.level = blink_bit ? rgbfb_pkg::LEVEL_FULL : '0;
                    c_n.phase = c.phase + 5'd1;
                    flip = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.action)
        begin
            // Undefined pattern codes leave the state alone.
            if (cmd.pattern <= rgbfb_pkg::PAT_COMM)
            begin
                nxt.pattern = cmd.pattern;
                nxt.chan = '0;
                if (cmd.pattern != rgbfb_pkg::PAT_OFF)
                    nxt.stop_permitted = 1'b0;
            end
        end
        else if (cur.pattern == rgbfb_pkg::PAT_OFF)
        begin
            nxt.chan = '0;
            nxt.stop_permitted = 1'b1;
        end
        else if (mode != MODE_NONE)
        begin
            if (end_pat)
            begin
                nxt.pattern = rgbfb_pkg::PAT_OFF;
                nxt.chan = '0;
            end
            else
                nxt.chan[ch] = c_n;
            if (flip)
            begin
                if (cur.pattern == rgbfb_pkg::PAT_MULTI)
                    nxt.blink_multi = ~cur.blink_multi;
                else
                    nxt.blink_comm = ~cur.blink_comm;
            end
        end
    end

endmodule

[hdl/rgb_led_fade_blink_sequencer_core.sv]
// Top level of the RGB LED fade and blink sequencer with its output pipeline.

// The block takes one beat per clock cycle while item_stall is low, each either a
// millisecond tick or a command that starts a pattern, and returns exactly one
// result beat for each. The pattern state is updated in the cycle a beat is
// accepted; the result then passes three registered stages (levels, scale
// product, divide by 100 and clamp), and the sustained rate is one beat per
// cycle while the result side does not stall.
// Configuration writes are taken in every cycle and must be made while idle.
`include "rgb_led_fade_blink_sequencer_core_macros.svh"

module rgb_led_fade_blink_sequencer_core #(
    parameter int COMPARE_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rgbfb_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output rgbfb_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam logic [32:0] CMP_LIMIT = (33'd1 << COMPARE_WIDTH) - 33'd1;

    rgbfb_pkg::cfg_t       cfg_reg;
    rgbfb_pkg::seq_state_t state_reg;
    rgbfb_pkg::seq_state_t state_next;

    logic                                    s1_valid_reg;
    logic [2:0][rgbfb_pkg::LEVEL_W-1:0]      s1_level_reg;
    logic [2:0]                              s1_pattern_reg;
    logic                                    s1_stop_reg;

    logic                                    s2_valid_reg;
    logic [2:0][rgbfb_pkg::LEVEL_W-1:0]      s2_level_reg;
    logic [2:0][rgbfb_pkg::PROD_W-1:0]       s2_prod_reg;
    logic [2:0]                              s2_pattern_reg;
    logic                                    s2_stop_reg;

    logic                                    result_valid_reg;
    rgbfb_pkg::result_t                      result_reg;
    rgbfb_pkg::result_t                      result_next;
    logic [2:0][rgbfb_pkg::PROD_W-1:0]       prod_next;

    logic ready3;
    logic ready2;
    logic ready1;
    logic accept;

    assign ready3 = !result_valid_reg || !result_stall;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign accept = item_valid && ready1;

    assign item_stall   = !ready1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    rgbfb_step u_step (
        .cur (state_reg),
        .cmd (item),
        .cfg (cfg_reg),
        .nxt (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_full_scale  <= rgbfb_pkg::RST_DUTY_FULL_SCALE;
            cfg_reg.rise_step_ticks  <= rgbfb_pkg::RST_RISE_STEP_TICKS;
            cfg_reg.fall_step_ticks  <= rgbfb_pkg::RST_FALL_STEP_TICKS;
            cfg_reg.hold_ticks       <= rgbfb_pkg::RST_HOLD_TICKS;
            cfg_reg.slow_blink_ticks <= rgbfb_pkg::RST_SLOW_BLINK_TICKS;
            cfg_reg.fast_blink_ticks <= rgbfb_pkg::RST_FAST_BLINK_TICKS;
            cfg_reg.blink_toggles    <= rgbfb_pkg::RST_BLINK_TOGGLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbfb_pkg::CFG_DUTY_FULL_SCALE:  cfg_reg.duty_full_scale  <= cfg_data;
                rgbfb_pkg::CFG_RISE_STEP_TICKS:  cfg_reg.rise_step_ticks  <= cfg_data[11:0];
                rgbfb_pkg::CFG_FALL_STEP_TICKS:  cfg_reg.fall_step_ticks  <= cfg_data[11:0];
                rgbfb_pkg::CFG_HOLD_TICKS:       cfg_reg.hold_ticks       <= cfg_data[11:0];
                rgbfb_pkg::CFG_SLOW_BLINK_TICKS: cfg_reg.slow_blink_ticks <= cfg_data[11:0];
                rgbfb_pkg::CFG_FAST_BLINK_TICKS: cfg_reg.fast_blink_ticks <= cfg_data[11:0];
                rgbfb_pkg::CFG_BLINK_TOGGLES:    cfg_reg.blink_toggles    <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pattern        <= rgbfb_pkg::PAT_WAKE;
            state_reg.chan           <= '0;
            state_reg.stop_permitted <= 1'b0;
            state_reg.blink_multi    <= 1'b0;
            state_reg.blink_comm     <= 1'b0;
            s1_valid_reg             <= 1'b0;
            s2_valid_reg             <= 1'b0;
            result_valid_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (ready1)
                s1_valid_reg <= item_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                result_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod_next[i] = rgbfb_pkg::PROD_W'(cfg_reg.duty_full_scale) *
                           rgbfb_pkg::PROD_W'(s1_level_reg[i]);
    end

    always_comb
    begin
        logic [2:0][rgbfb_pkg::DUTY_W-1:0] cmp;
        for (int i = 0; i < 3; i++)
        begin
            cmp[i] = rgbfb_pkg::div100(s2_prod_reg[i]);
            if (33'(cmp[i]) > CMP_LIMIT)
                cmp[i] = CMP_LIMIT[rgbfb_pkg::DUTY_W-1:0];
        end
        result_next.red_level       = s2_level_reg[rgbfb_pkg::CH_RED];
        result_next.green_level     = s2_level_reg[rgbfb_pkg::CH_GREEN];
        result_next.blue_level      = s2_level_reg[rgbfb_pkg::CH_BLUE];
        result_next.red_compare     = cmp[rgbfb_pkg::CH_RED];
        result_next.green_compare   = cmp[rgbfb_pkg::CH_GREEN];
        result_next.blue_compare    = cmp[rgbfb_pkg::CH_BLUE];
        result_next.current_pattern = s2_pattern_reg;
        result_next.sleep_allowed   = s2_stop_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            for (int i = 0; i < 3; i++)
                s1_level_reg[i] <= state_next.chan[i].level;
            s1_pattern_reg <= state_next.pattern;
            s1_stop_reg    <= state_next.stop_permitted;
        end
        if (ready2)
        begin
            s2_level_reg   <= s1_level_reg;
            s2_prod_reg    <= prod_next;
            s2_pattern_reg <= s1_pattern_reg;
            s2_stop_reg    <= s1_stop_reg;
        end
        if (ready3)
            result_reg <= result_next;
    end

    `RGBFB_ASSERT(a_off_clears_levels, (state_reg.pattern != rgbfb_pkg::PAT_OFF) || (state_reg.chan == '0), "Off pattern holds a nonzero channel state.")
    `RGBFB_ASSERT(a_one_channel_lit, $countones({state_reg.chan[0].level != '0, state_reg.chan[1].level != '0, state_reg.chan[2].level != '0}) <= 1, "More than one channel is lit.")
    `RGBFB_ASSERT(a_sleep_only_off, !state_reg.stop_permitted || (state_reg.pattern == rgbfb_pkg::PAT_OFF), "Sleep is allowed while a pattern runs.")
    `RGBFB_ASSERT_NEXT(a_result_follows_pipe, s2_valid_reg && ready3, result_valid_reg, "A finished beat did not reach the result register.")

endmodule

[sim/rgb_led_fade_blink_sequencer_core_tb.sv]
// Self-checking testbench for the RGB LED fade and blink sequencer core.
`timescale 1ns / 1ps

module rgb_led_fade_blink_sequencer_core_tb;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic [2:0] PAT_UNDEF_LOW  = 3'd6;
    localparam logic [2:0] PAT_UNDEF_HIGH = 3'd7;

    localparam int unsigned RANDOM_BEATS = 1000;
    localparam int unsigned PHASE_BEATS  = 250;
    localparam int unsigned SPAN_CAP     = 600;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    rgbfb_pkg::item_t     item;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    rgbfb_pkg::result_t   result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [15:0]          cfg_data;

    rgb_led_fade_blink_sequencer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    rgbfb_pkg::cfg_t model_cfg;
    logic [2:0]      seq_pattern;
    int unsigned     chan_level [3];
    int unsigned     chan_phase [3];
    int unsigned     chan_count [3];
    bit              chan_armed [3];
    bit              sleep_ok;
    bit              multi_bit;
    bit              comm_bit;

    rgbfb_pkg::result_t expected_led_states [$];
    rgbfb_pkg::result_t led_want;
    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned results_checked = 0;
    int unsigned settings_applied = 0;
    bit          steady = 1'b0;

    function automatic void clear_channels();
        for (int ch = 0; ch < 3; ch++)
        begin
            chan_level[ch] = 0;
            chan_phase[ch] = 0;
            chan_armed[ch] = 1'b0;
            chan_count[ch] = 0;
        end
    endfunction

    function automatic void begin_pattern(logic [2:0] p);
        seq_pattern = p;
        clear_channels();
        if (p != rgbfb_pkg::PAT_OFF)
            sleep_ok = 1'b0;
    endfunction

    function automatic void reset_model();
        model_cfg.duty_full_scale  = rgbfb_pkg::RST_DUTY_FULL_SCALE;
        model_cfg.rise_step_ticks  = rgbfb_pkg::RST_RISE_STEP_TICKS;
        model_cfg.fall_step_ticks  = rgbfb_pkg::RST_FALL_STEP_TICKS;
        model_cfg.hold_ticks       = rgbfb_pkg::RST_HOLD_TICKS;
        model_cfg.slow_blink_ticks = rgbfb_pkg::RST_SLOW_BLINK_TICKS;
        model_cfg.fast_blink_ticks = rgbfb_pkg::RST_FAST_BLINK_TICKS;
        model_cfg.blink_toggles    = rgbfb_pkg::RST_BLINK_TOGGLES;
        seq_pattern = rgbfb_pkg::PAT_WAKE;
        clear_channels();
        sleep_ok  = 1'b0;
        multi_bit = 1'b0;
        comm_bit  = 1'b0;
    endfunction

    function automatic void load_register(logic [2:0] idx, logic [15:0] data);
        case (idx)
            rgbfb_pkg::CFG_DUTY_FULL_SCALE:  model_cfg.duty_full_scale  = data;
            rgbfb_pkg::CFG_RISE_STEP_TICKS:  model_cfg.rise_step_ticks  = data[11:0];
            rgbfb_pkg::CFG_FALL_STEP_TICKS:  model_cfg.fall_step_ticks  = data[11:0];
            rgbfb_pkg::CFG_HOLD_TICKS:       model_cfg.hold_ticks       = data[11:0];
            rgbfb_pkg::CFG_SLOW_BLINK_TICKS: model_cfg.slow_blink_ticks = data[11:0];
            rgbfb_pkg::CFG_FAST_BLINK_TICKS: model_cfg.fast_blink_ticks = data[11:0];
            rgbfb_pkg::CFG_BLINK_TOGGLES:    model_cfg.blink_toggles    = data[4:0];
            default: ;
        endcase
    endfunction

    // Arming a stopped timer consumes the tick without counting it.
    function automatic bit timer_fires(int ch, int unsigned interval);
        if (!chan_armed[ch])
        begin
            chan_armed[ch] = 1'b1;
            chan_count[ch] = 0;
            return 1'b0;
        end
        if (chan_count[ch] < rgbfb_pkg::TICK_MAX)
            chan_count[ch]++;
        return chan_count[ch] >= interval;
    endfunction

    function automatic void fade_up(int ch);
        if (timer_fires(ch, model_cfg.rise_step_ticks))
        begin
            chan_armed[ch] = 1'b0;
            if (chan_level[ch] < 100)
                chan_level[ch]++;
        end
        if (chan_level[ch] >= rgbfb_pkg::FADE_TOP)
        begin
            chan_phase[ch] = (chan_phase[ch] + 1) & 31;
            chan_armed[ch] = 1'b0;
        end
    endfunction

    function automatic void fade_down(int ch);
        if (timer_fires(ch, model_cfg.fall_step_ticks))
        begin
            chan_armed[ch] = 1'b0;
            if (chan_level[ch] > 0)
                chan_level[ch]--;
        end
        if (chan_level[ch] == 0)
            begin_pattern(rgbfb_pkg::PAT_OFF);
    endfunction

    function automatic void blink_step(int ch, int unsigned interval, bit is_comm);
        bit vb;
        vb = is_comm ? comm_bit : multi_bit;
        if (chan_phase[ch] >= model_cfg.blink_toggles)
            begin_pattern(rgbfb_pkg::PAT_OFF);
        else if (timer_fires(ch, interval))
        begin
            chan_count[ch] = 0;
            chan_level[ch] = vb ? 100 : 0;
            chan_phase[ch] = (chan_phase[ch] + 1) & 31;
            if (is_comm)
                comm_bit = !vb;
            else
                multi_bit = !vb;
        end
    endfunction

    function automatic void fade_cycle(int ch);
        if (chan_phase[ch] == 0)
            fade_up(ch);
        else
            fade_down(ch);
    endfunction

    function automatic void tick_model();
        case (seq_pattern)
            rgbfb_pkg::PAT_OFF:
            begin
                clear_channels();
                sleep_ok = 1'b1;
            end
            rgbfb_pkg::PAT_WAKE:
            begin
                if (chan_phase[rgbfb_pkg::CH_BLUE] == 0)
                    fade_up(rgbfb_pkg::CH_BLUE);
                else if (chan_phase[rgbfb_pkg::CH_BLUE] == 1)
                begin
                    if (timer_fires(rgbfb_pkg::CH_BLUE, model_cfg.hold_ticks))
                    begin
                        chan_armed[rgbfb_pkg::CH_BLUE] = 1'b0;
                        chan_phase[rgbfb_pkg::CH_BLUE] = 2;
                    end
                end
                else
                    fade_down(rgbfb_pkg::CH_BLUE);
            end
            rgbfb_pkg::PAT_SUCCESS: fade_cycle(rgbfb_pkg::CH_GREEN);
            rgbfb_pkg::PAT_MULTI:
                blink_step(rgbfb_pkg::CH_BLUE, model_cfg.slow_blink_ticks, 1'b0);
            rgbfb_pkg::PAT_FAIL:    fade_cycle(rgbfb_pkg::CH_RED);
            rgbfb_pkg::PAT_COMM:
                blink_step(rgbfb_pkg::CH_RED, model_cfg.fast_blink_ticks, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] scaled_compare(int unsigned level);
        longint unsigned v;
        v = 64'(model_cfg.duty_full_scale);
        v = v * level / 100;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic rgbfb_pkg::result_t advance_sequencer(rgbfb_pkg::item_t it);
        rgbfb_pkg::result_t r;
        if (it.action == ACT_START)
        begin
            if (it.pattern <= rgbfb_pkg::PAT_COMM)
                begin_pattern(it.pattern);
        end
        else
            tick_model();
        r.red_level       = chan_level[rgbfb_pkg::CH_RED][6:0];
        r.green_level     = chan_level[rgbfb_pkg::CH_GREEN][6:0];
        r.blue_level      = chan_level[rgbfb_pkg::CH_BLUE][6:0];
        r.red_compare     = scaled_compare(chan_level[rgbfb_pkg::CH_RED]);
        r.green_compare   = scaled_compare(chan_level[rgbfb_pkg::CH_GREEN]);
        r.blue_compare    = scaled_compare(chan_level[rgbfb_pkg::CH_BLUE]);
        r.current_pattern = seq_pattern;
        r.sleep_allowed   = sleep_ok;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                expected_led_states.push_back(advance_sequencer(item));
            if (result_valid && !result_stall)
            begin
                if (expected_led_states.size() == 0)
                begin
                    $error("result beat arrived with no expected LED state pending");
                    errors++;
                end
                else
                begin
                    led_want = expected_led_states.pop_front();
                    check_field("red_level", led_want.red_level, result.red_level);
                    check_field("green_level", led_want.green_level, result.green_level);
                    check_field("blue_level", led_want.blue_level, result.blue_level);
                    check_field("red_compare", led_want.red_compare, result.red_compare);
                    check_field("green_compare", led_want.green_compare,
                                result.green_compare);
                    check_field("blue_compare", led_want.blue_compare, result.blue_compare);
                    check_field("current_pattern", led_want.current_pattern,
                                result.current_pattern);
                    check_field("sleep_allowed", led_want.sleep_allowed,
                                result.sleep_allowed);
                    results_checked++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_stall <= !steady && ($urandom_range(0, 99) < 9);
    end

    task automatic send_item(logic act, logic [2:0] pat);
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= {act, pat};
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic tick();
        logic [2:0] p;
        p = 3'($urandom_range(0, 7));
        send_item(ACT_TICK, p);
    endtask

    task automatic start(logic [2:0] pat);
        send_item(ACT_START, pat);
    endtask

    task automatic idle_wait();
        item_valid <= 1'b0;
        while (expected_led_states.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_config(rgbfb_pkg::cfg_t c);
        idle_wait();
        write_register(rgbfb_pkg::CFG_DUTY_FULL_SCALE, c.duty_full_scale);
        write_register(rgbfb_pkg::CFG_RISE_STEP_TICKS, {4'd0, c.rise_step_ticks});
        write_register(rgbfb_pkg::CFG_FALL_STEP_TICKS, {4'd0, c.fall_step_ticks});
        write_register(rgbfb_pkg::CFG_HOLD_TICKS, {4'd0, c.hold_ticks});
        write_register(rgbfb_pkg::CFG_SLOW_BLINK_TICKS, {4'd0, c.slow_blink_ticks});
        write_register(rgbfb_pkg::CFG_FAST_BLINK_TICKS, {4'd0, c.fast_blink_ticks});
        write_register(rgbfb_pkg::CFG_BLINK_TOGGLES, {11'd0, c.blink_toggles});
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic rgbfb_pkg::cfg_t uniform_regs(logic [15:0] duty, logic [11:0] ticks,
                                                     logic [4:0] toggles);
        rgbfb_pkg::cfg_t c;
        c.duty_full_scale  = duty;
        c.rise_step_ticks  = ticks;
        c.fall_step_ticks  = ticks;
        c.hold_ticks       = ticks;
        c.slow_blink_ticks = ticks;
        c.fast_blink_ticks = ticks;
        c.blink_toggles    = toggles;
        return c;
    endfunction

    function automatic logic [11:0] pick_interval();
        int unsigned r;
        logic [11:0] v;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = 12'($urandom_range(1, 2));
        else if (r < 90)
            v = 12'($urandom_range(3, 6));
        else if (r < 97)
            v = 12'($urandom_range(7, 40));
        else
            v = 12'($urandom_range(1, 4095));
        return v;
    endfunction

    function automatic rgbfb_pkg::cfg_t random_regs();
        rgbfb_pkg::cfg_t c;
        int unsigned     r;
        r = $urandom_range(0, 99);
        if (r < 35)
            c.duty_full_scale = 16'hFFFF;
        else if (r < 50)
            c.duty_full_scale = 16'd1;
        else
            c.duty_full_scale = 16'($urandom_range(1, 65535));
        c.rise_step_ticks  = pick_interval();
        c.fall_step_ticks  = pick_interval();
        c.hold_ticks       = pick_interval();
        c.slow_blink_ticks = pick_interval();
        c.fast_blink_ticks = pick_interval();
        if ($urandom_range(0, 99) < 15)
            c.blink_toggles = 5'd31;
        else
            c.blink_toggles = 5'($urandom_range(1, 8));
        return c;
    endfunction

    // Ticks a pattern needs to run to its end, capped to keep phases short.
    function automatic int unsigned expected_span(logic [2:0] pat, rgbfb_pkg::cfg_t c);
        int unsigned n;
        case (pat)
            rgbfb_pkg::PAT_WAKE:
                n = 99 * (c.rise_step_ticks + 1) + c.hold_ticks + 1
                    + 99 * (c.fall_step_ticks + 1) + 2;
            rgbfb_pkg::PAT_SUCCESS, rgbfb_pkg::PAT_FAIL:
                n = 99 * (c.rise_step_ticks + 1) + 99 * (c.fall_step_ticks + 1) + 2;
            rgbfb_pkg::PAT_MULTI:
                n = c.blink_toggles * (c.slow_blink_ticks + 1) + 2;
            rgbfb_pkg::PAT_COMM:
                n = c.blink_toggles * (c.fast_blink_ticks + 1) + 2;
            default:
                n = 2;
        endcase
        if (n > SPAN_CAP)
            n = SPAN_CAP;
        return n;
    endfunction

    task automatic test_pattern_commands();
        tick();
        tick();
        start(PAT_UNDEF_LOW);
        start(PAT_UNDEF_HIGH);
        start(rgbfb_pkg::PAT_OFF);
        tick();
        start(rgbfb_pkg::PAT_SUCCESS);
        start(rgbfb_pkg::PAT_FAIL);
        start(rgbfb_pkg::PAT_MULTI);
        start(rgbfb_pkg::PAT_COMM);
        tick();
        start(rgbfb_pkg::PAT_WAKE);
        tick();
    endtask

    task automatic test_blink_end();
        apply_config(uniform_regs(16'd1, 12'd1, 5'd1));
        start(rgbfb_pkg::PAT_COMM);
        repeat (4) tick();
        start(rgbfb_pkg::PAT_COMM);
        repeat (2) tick();
    endtask

    task automatic test_register_extremes();
        apply_config(uniform_regs(16'hFFFF, 12'hFFF, 5'h1F));
        start(rgbfb_pkg::PAT_FAIL);
        repeat (2) tick();
    endtask

    task automatic test_random_sequences();
        rgbfb_pkg::cfg_t regs;
        int unsigned     done;
        int unsigned     phase_base;
        int unsigned     span;
        int              phase_no;
        logic [2:0]      pat;
        logic [2:0]      noise_pat;
        logic            noise_act;
        done = 0;
        phase_no = 0;
        while (done < RANDOM_BEATS)
        begin
            regs = random_regs();
            apply_config(regs);
            steady = (phase_no == 1);
            phase_base = done;
            while (done - phase_base < PHASE_BEATS && done < RANDOM_BEATS)
            begin
                pat = 3'($urandom_range(rgbfb_pkg::PAT_OFF, rgbfb_pkg::PAT_COMM));
                start(pat);
                done++;
                if ($urandom_range(0, 99) < 70)
                    span = expected_span(pat, regs);
                else
                    span = $urandom_range(0, 30);
                for (int k = 0; k < span && done < RANDOM_BEATS; k++)
                begin
                    if ($urandom_range(0, 99) < 4)
                    begin
                        noise_act = 1'($urandom_range(0, 1));
                        noise_pat = 3'($urandom_range(0, 7));
                        send_item(noise_act, noise_pat);
                    end
                    else
                        tick();
                    done++;
                end
            end
            steady = 1'b0;
            phase_no++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        reset_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pattern_commands();
        test_blink_end();
        test_register_extremes();
        test_random_sequences();
        idle_wait();

        $display("Sent %0d beats (ticks, pattern starts, undefined starts) over %0d settings.",
                 beats_sent, settings_applied);
        $display("Checked %0d result beats; %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d result beats outstanding.", expected_led_states.size());
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/rgbfb_pkg.sv
hdl/rgbfb_step.sv
hdl/rgb_led_fade_blink_sequencer_core.sv
sim/rgb_led_fade_blink_sequencer_core_tb.sv
